// File: sv/hcbd_pkg.sv
package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // One result item as it leaves the decoder.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       payload_valid;
        logic       body_end;
        logic       format_error;
    } hcbd_result_t;

endpackage

// File: sv/hcbd_in_if.sv
interface hcbd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

// File: sv/hcbd_out_if.sv
interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       payload_valid;
    logic       body_end;
    logic       format_error;

    modport source (output valid, output out_byte, output payload_valid,
                    output body_end, output format_error, input ready);
    modport sink   (input valid, input out_byte, input payload_valid,
                    input body_end, input format_error, output ready);
endinterface

// File: sv/hcbd_core.sv
module hcbd_core
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         in_command,
    input  logic [7:0]   in_byte,
    output logic         res_valid,
    input  logic         res_ready,
    output hcbd_result_t res
);

    typedef enum logic [2:0] {
        MODE_SKIP_WS   = 3'd0,
        MODE_DIGITS    = 3'd1,
        MODE_SKIP_LINE = 3'd2,
        MODE_DATA      = 3'd3,
        MODE_DONE      = 3'd4,
        MODE_ERROR     = 3'd5
    } mode_t;

    localparam logic [SIZE_BITS-1:0] COUNT_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

    logic                 s1_valid_reg;
    logic                 s1_cmd_reg;
    logic [7:0]           s1_byte_reg;
    logic                 s1_go;

    mode_t                mode_reg, mode_next;
    logic [SIZE_BITS-1:0] count_reg, count_next;
    logic                 seen_reg, seen_next;

    logic                 produce;
    hcbd_result_t         res_comb;
    logic                 is_hex;
    logic [3:0]           hex_val;
    logic                 is_space;
    logic                 overflow;

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (s1_byte_reg >= 8'h30 && s1_byte_reg <= 8'h39)
        begin
            hex_val = 4'(s1_byte_reg - 8'h30);
        end
        else if (s1_byte_reg >= 8'h61 && s1_byte_reg <= 8'h66)
        begin
            hex_val = 4'(s1_byte_reg - 8'h57);
        end
        else if (s1_byte_reg >= 8'h41 && s1_byte_reg <= 8'h46)
        begin
            hex_val = 4'(s1_byte_reg - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign is_space = (s1_byte_reg == 8'h20) || (s1_byte_reg inside {[8'h09:8'h0D]});
    // Shifting in one more digit would lose a set bit at the top.
    assign overflow = |count_reg[SIZE_BITS-1 -: 4];

    always_comb
    begin
        mode_next = mode_reg;
        count_next = count_reg;
        seen_next = seen_reg;
        produce = 1'b0;
        res_comb = '0;
        if (s1_cmd_reg == CMD_RESTART)
        begin
            mode_next = MODE_SKIP_WS;
            count_next = '0;
            seen_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_SKIP_WS, MODE_DIGITS:
                begin
                    if (is_hex)
                    begin
                        if (overflow)
                        begin
                            mode_next = MODE_ERROR;
                            count_next = '0;
                            seen_next = 1'b0;
                            produce = 1'b1;
                            res_comb.format_error = 1'b1;
                        end
                        else
                        begin
                            count_next = {count_reg[SIZE_BITS-5:0], hex_val};
                            seen_next = 1'b1;
                            mode_next = MODE_DIGITS;
                        end
                    end
                    else if (mode_reg == MODE_SKIP_WS && !seen_reg)
                    begin
                        if (!is_space)
                        begin
                            mode_next = MODE_ERROR;
                            count_next = '0;
                            seen_next = 1'b0;
                            produce = 1'b1;
                            res_comb.format_error = 1'b1;
                        end
                    end
                    else if (s1_byte_reg == CHAR_LF)
                    begin
                        seen_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            mode_next = MODE_DONE;
                            produce = 1'b1;
                            res_comb.body_end = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_DATA;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_SKIP_LINE;
                    end
                end
                MODE_SKIP_LINE:
                begin
                    if (s1_byte_reg == CHAR_LF)
                    begin
                        seen_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            mode_next = MODE_DONE;
                            produce = 1'b1;
                            res_comb.body_end = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_DATA;
                        end
                    end
                end
                MODE_DATA:
                begin
                    count_next = count_reg - COUNT_ONE;
                    if (count_reg == COUNT_ONE)
                    begin
                        mode_next = MODE_SKIP_WS;
                    end
                    produce = 1'b1;
                    res_comb.out_byte = s1_byte_reg;
                    res_comb.payload_valid = 1'b1;
                end
                MODE_ERROR:
                begin
                    produce = 1'b1;
                    res_comb.format_error = 1'b1;
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
        end
    end

    // The held item moves on when it makes no result or the result stage can take one.
    assign s1_go     = s1_valid_reg && (!produce || res_ready);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign res_valid = s1_valid_reg && produce;
    assign res       = res_comb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mode_reg <= MODE_SKIP_WS;
            count_reg <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_go)
            begin
                mode_reg <= mode_next;
                count_reg <= count_next;
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_cmd_reg <= in_command;
            s1_byte_reg <= in_byte;
        end
    end

    a_data_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_DATA |-> count_reg != '0)
        else $error("data mode with zero chunk count");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_cmd_reg == CMD_RESTART) |=> (mode_reg == MODE_SKIP_WS && count_reg == '0
                                                  && !seen_reg))
        else $error("restart did not clear decoder state");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR && !(s1_go && s1_cmd_reg == CMD_RESTART))
        |=> mode_reg == MODE_ERROR)
        else $error("error mode left without restart");

    a_seen_only_on_size_line: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (mode_reg == MODE_DIGITS || mode_reg == MODE_SKIP_LINE))
        else $error("digit flag set outside a size line");

endmodule

// File: sv/hcbd_out_stage.sv
module hcbd_out_stage
    import hcbd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    output logic          res_ready,
    input  hcbd_result_t  res,
    hcbd_out_if.source    result
);

    logic         out_valid_reg;
    hcbd_result_t out_data_reg;

    assign res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_byte      = out_data_reg.out_byte;
    assign result.payload_valid = out_data_reg.payload_valid;
    assign result.body_end      = out_data_reg.body_end;
    assign result.format_error  = out_data_reg.format_error;

endmodule

// File: sv/http_chunked_body_decoder_unit.sv
// An accepted item that makes a result passes through the input register and then the
// result register before it shows on the result channel. Throughput: one item per cycle while
// no result stalls; the decoder state loop updates in the same cycle.
// Reset: rst_n is asynchronous and active low; it empties both registers and returns the
// parser to skipping whitespace before a size line, with the chunk count and digit flag clear.
module http_chunked_body_decoder_unit
    import hcbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    hcbd_in_if.sink    body,
    hcbd_out_if.source result
);

    // The core holds one item in its input register. Its mode, chunk count and
    // digit flag are updated as that item leaves, so each item sees the state
    // left by the one before it. Items that produce nothing (skipped whitespace,
    // size digits, extension bytes, bytes after the end) leave without using
    // the result register, so they never wait on the downstream side.
    logic         res_valid;
    logic         res_ready;
    hcbd_result_t res;

    hcbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (body.valid),
        .in_ready   (body.ready),
        .in_command (body.command),
        .in_byte    (body.in_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // The result register lets the core move on while a finished item waits
    // to be taken downstream.
    hcbd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .result    (result)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the chunked body decoder. A generator builds the whole
// stream of body items up front: a short directed opening, then mostly well-formed
// chunked bodies with random sizes, extensions and payload, mixed with broken size
// lines, size overflows, cut-off chunks and raw noise. The driver feeds that queue
// into the input channel, and on every accepted item a local model of the decoder
// predicts the result item, if any. The monitor compares every accepted result item
// field by field against the oldest prediction.
module tb_top;
    import hcbd_pkg::*;

    localparam int SIZE_BITS      = SIZE_BITS_DEFAULT;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int QUIET_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 10;

    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    // Parser modes of the decoder, as the model keeps them.
    typedef enum logic [2:0] {
        PM_SKIP_WS   = 3'd0,
        PM_DIGITS    = 3'd1,
        PM_SKIP_LINE = 3'd2,
        PM_DATA      = 3'd3,
        PM_DONE      = 3'd4,
        PM_ERROR     = 3'd5
    } parse_mode_t;

    // One pending body item, with the pacing the driver applies before it.
    typedef struct {
        logic        command;
        logic [7:0]  in_byte;
        int unsigned gap;
        bit          drain;
        bit          quiet;
    } body_item_t;

    logic clk;
    logic rst_n;

    hcbd_in_if  body_if();
    hcbd_out_if result_if();

    http_chunked_body_decoder_unit #(
        .SIZE_BITS (SIZE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body_if),
        .result (result_if)
    );

    // Model state of the decoder.
    parse_mode_t          dec_mode       = PM_SKIP_WS;
    logic [SIZE_BITS-1:0] dec_remaining  = '0;
    bit                   dec_seen_digit = 1'b0;

    body_item_t   pending_items[$];
    hcbd_result_t expected_results[$];

    // Generator pacing knobs.
    bit bursty;
    bit drain_next;
    int quiet_from;
    int total_items;

    // Driver and monitor bookkeeping.
    body_item_t next_item;
    bit         have_item;
    int         hold_cycles;
    int         settled_cycles;
    bit         quiet_tail;
    int         stall_left;
    int         calm_left;
    int         idle_cycles;

    int accepted_items;
    int restart_count;
    int drain_pauses;
    int payload_count;
    int body_end_count;
    int error_count;
    int fail_count;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Returns {1, value} for a hex digit and zero for anything else.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h61 + 8'd10)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return b == CHAR_SP || (b >= CHAR_TAB && b <= CHAR_CR);
    endfunction

    // Steps the decoder model by one body item. has_res tells whether the item
    // gives a result item, and res holds it.
    function automatic void decode_step(input logic cmd, input logic [7:0] b,
                                        output bit has_res, output hcbd_result_t res);
        logic [4:0] hv;
        bit         bad;
        bit         line_end;
        hv       = hex_nibble(b);
        bad      = 1'b0;
        line_end = 1'b0;
        has_res  = 1'b0;
        res      = '0;
        if (cmd == CMD_RESTART) begin
            dec_mode       = PM_SKIP_WS;
            dec_remaining  = '0;
            dec_seen_digit = 1'b0;
            return;
        end
        case (dec_mode)
            PM_SKIP_WS, PM_DIGITS: begin
                if (hv[4]) begin
                    // One more nibble would not fit, so the size overflows.
                    if (dec_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
                        bad = 1'b1;
                    end else begin
                        dec_remaining  = {dec_remaining[SIZE_BITS-5:0], hv[3:0]};
                        dec_seen_digit = 1'b1;
                        dec_mode       = PM_DIGITS;
                    end
                end else if (dec_mode == PM_SKIP_WS && !dec_seen_digit) begin
                    bad = !is_space(b);
                end else if (b == CHAR_LF) begin
                    line_end = 1'b1;
                end else begin
                    dec_mode = PM_SKIP_LINE;
                end
            end
            PM_SKIP_LINE: begin
                line_end = (b == CHAR_LF);
            end
            PM_DATA: begin
                dec_remaining = dec_remaining - 1'b1;
                if (dec_remaining == '0) dec_mode = PM_SKIP_WS;
                has_res           = 1'b1;
                res.out_byte      = b;
                res.payload_valid = 1'b1;
            end
            PM_ERROR: begin
                has_res          = 1'b1;
                res.format_error = 1'b1;
            end
            default: begin
            end
        endcase
        if (bad) begin
            dec_mode         = PM_ERROR;
            dec_remaining    = '0;
            dec_seen_digit   = 1'b0;
            has_res          = 1'b1;
            res.format_error = 1'b1;
        end
        if (line_end) begin
            dec_seen_digit = 1'b0;
            if (dec_remaining == '0) begin
                dec_mode     = PM_DONE;
                has_res      = 1'b1;
                res.body_end = 1'b1;
            end else begin
                dec_mode = PM_DATA;
            end
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        if ($urandom_range(0, 1) == 0) return 8'h61 + 8'(nib) - 8'd10;
        return 8'h41 + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] rand_space();
        int unsigned k;
        k = $urandom_range(0, 5);
        if (k == 0) return CHAR_SP;
        return 8'h08 + 8'(k);
    endfunction

    // Queues one body item; gaps and drain pauses are drawn only outside the
    // quiet tail of the run, and gaps only in bursty stretches.
    task automatic add_item(input logic cmd, input logic [7:0] b);
        body_item_t it;
        it.command = cmd;
        it.in_byte = b;
        it.quiet   = pending_items.size() >= quiet_from;
        it.drain   = drain_next && !it.quiet;
        it.gap     = 0;
        if (!it.quiet && bursty && $urandom_range(0, 4) == 0) it.gap = $urandom_range(1, 15);
        drain_next = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic add_data(input int unsigned count);
        repeat (count) add_item(CMD_PROCESS, 8'($urandom_range(0, 255)));
    endtask

    // A size line: optional leading whitespace, the size in hex with the odd
    // leading zero, then one of the legal ways to end the line.
    task automatic add_size_line(input logic [SIZE_BITS-1:0] size);
        int ndig;
        ndig = 1;
        repeat ($urandom_range(0, 2)) add_item(CMD_PROCESS, rand_space());
        while (ndig < SIZE_BITS / 4 && (size >> (4 * ndig)) != '0) ndig++;
        if (ndig < SIZE_BITS / 4 && $urandom_range(0, 3) == 0) ndig++;
        for (int i = ndig - 1; i >= 0; i--) add_item(CMD_PROCESS, hex_char(size[4*i +: 4]));
        case ($urandom_range(0, 3))
            0: add_item(CMD_PROCESS, CHAR_LF);
            1: begin
                add_item(CMD_PROCESS, CHAR_CR);
                add_item(CMD_PROCESS, CHAR_LF);
            end
            default: begin
                // Chunk extension: any bytes up to the line feed are dropped.
                add_item(CMD_PROCESS, ($urandom_range(0, 1) == 0) ? CHAR_SEMI : CHAR_SP);
                repeat ($urandom_range(0, 5)) begin
                    logic [7:0] b;
                    do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
                    add_item(CMD_PROCESS, b);
                end
                add_item(CMD_PROCESS, CHAR_LF);
            end
        endcase
    endtask

    // Driver: presents the queued items, applies gaps, and holds an item marked
    // for draining until every predicted result has come back.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            body_if.valid   <= 1'b0;
            body_if.command <= CMD_PROCESS;
            body_if.in_byte <= '0;
            have_item      = 1'b0;
            hold_cycles    = 0;
            settled_cycles = 0;
        end else begin : drive
            bit           show;
            bit           has_res;
            hcbd_result_t res;
            show = body_if.valid && !body_if.ready;
            if (body_if.valid && body_if.ready) begin
                decode_step(body_if.command, body_if.in_byte, has_res, res);
                if (has_res) expected_results.push_back(res);
                accepted_items++;
                if (body_if.command == CMD_RESTART) restart_count++;
            end
            settled_cycles = (expected_results.size() == 0) ? settled_cycles + 1 : 0;
            if (!show) begin
                if (!have_item && pending_items.size() != 0) begin
                    next_item   = pending_items.pop_front();
                    have_item   = 1'b1;
                    hold_cycles = next_item.gap;
                    if (next_item.quiet) quiet_tail <= 1'b1;
                end
                if (have_item) begin
                    if (hold_cycles != 0) begin
                        hold_cycles--;
                    end else if (!next_item.drain || settled_cycles >= SETTLE_CYCLES) begin
                        if (next_item.drain) drain_pauses++;
                        show = 1'b1;
                        body_if.command <= next_item.command;
                        body_if.in_byte <= next_item.in_byte;
                        have_item = 1'b0;
                    end
                end
            end
            body_if.valid <= show;
        end
    end

    // Monitor: checks each accepted result item and drives ready with random
    // stall bursts, broken up by calm stretches and switched off in the tail.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            stall_left = 0;
            calm_left  = 0;
        end else begin : watch
            hcbd_result_t want;
            if (result_if.valid && result_if.ready) begin
                if (result_if.payload_valid === 1'b1) payload_count++;
                if (result_if.body_end === 1'b1) body_end_count++;
                if (result_if.format_error === 1'b1) error_count++;
                if (expected_results.size() == 0) begin
                    $error("result item with none expected: out_byte %0h flags %b%b%b",
                           result_if.out_byte, result_if.payload_valid,
                           result_if.body_end, result_if.format_error);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (result_if.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, result_if.out_byte);
                        fail_count++;
                    end
                    if (result_if.payload_valid !== want.payload_valid) begin
                        $error("payload_valid: expected %0b, got %0b",
                               want.payload_valid, result_if.payload_valid);
                        fail_count++;
                    end
                    if (result_if.body_end !== want.body_end) begin
                        $error("body_end: expected %0b, got %0b",
                               want.body_end, result_if.body_end);
                        fail_count++;
                    end
                    if (result_if.format_error !== want.format_error) begin
                        $error("format_error: expected %0b, got %0b",
                               want.format_error, result_if.format_error);
                        fail_count++;
                    end
                end
            end
            if (calm_left != 0) begin
                calm_left--;
            end else if ($urandom_range(0, 199) == 0) begin
                calm_left = $urandom_range(50, 250);
            end
            if (stall_left != 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else if (!quiet_tail && calm_left == 0 && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either channel
    // means the decoder has hung.
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((body_if.valid && body_if.ready) || (result_if.valid && result_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
                         idle_cycles, expected_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned scenario;
        int unsigned size;
        int unsigned nchunks;
        int          directed_count;
        logic [7:0]  b;

        rst_n             = 1'b0;
        body_if.valid     = 1'b0;
        body_if.command   = CMD_PROCESS;
        body_if.in_byte   = '0;
        result_if.ready   = 1'b0;
        quiet_tail        = 1'b0;
        bursty            = 1'b0;
        drain_next        = 1'b0;
        quiet_from        = 1 << 30;
        have_item         = 1'b0;
        stall_left        = 0;
        calm_left         = 0;
        idle_cycles       = 0;
        accepted_items    = 0;
        restart_count     = 0;
        drain_pauses      = 0;
        payload_count     = 0;
        body_end_count    = 0;
        error_count       = 0;
        fail_count        = 0;

        // Directed opening. Space, tab, carriage return, vertical tab and form feed are skipped before a size.
        add_item(CMD_PROCESS, CHAR_SP);
        add_item(CMD_PROCESS, CHAR_TAB);
        add_item(CMD_PROCESS, CHAR_CR);
        add_item(CMD_PROCESS, CHAR_VT);
        add_item(CMD_PROCESS, CHAR_FF);
        // A 0x prefix is not a prefix: the x ends the digits, so this is a zero
        // size line and the body ends on the line feed.
        add_item(CMD_PROCESS, "0");
        add_item(CMD_PROCESS, "x");
        add_item(CMD_PROCESS, CHAR_LF);
        // Bytes after the end of the body are silent.
        add_item(CMD_PROCESS, "Q");
        add_item(CMD_RESTART, 8'hFF);
        // A bare line feed is whitespace; a size ended directly by a line feed
        // goes straight to data, here the two extreme byte values.
        add_item(CMD_PROCESS, CHAR_LF);
        add_item(CMD_PROCESS, "2");
        add_item(CMD_PROCESS, CHAR_LF);
        add_item(CMD_PROCESS, 8'h00);
        add_item(CMD_PROCESS, 8'hFF);
        // A sign where a size must start is an error, and the error sticks.
        add_item(CMD_PROCESS, "-");
        add_item(CMD_PROCESS, 8'h80);
        add_item(CMD_RESTART, 8'h00);
        // Eight digits fill the counter; the ninth overflows it.
        add_item(CMD_PROCESS, "F");
        add_item(CMD_PROCESS, "F");
        add_item(CMD_PROCESS, "F");
        add_item(CMD_PROCESS, "F");
        add_item(CMD_PROCESS, "f");
        add_item(CMD_PROCESS, "f");
        add_item(CMD_PROCESS, "f");
        add_item(CMD_PROCESS, "f");
        add_item(CMD_PROCESS, "A");
        add_item(CMD_RESTART, 8'h5A);

        directed_count = pending_items.size();
        total_items    = directed_count + RANDOM_ITEMS;
        quiet_from     = total_items - QUIET_ITEMS;
        drain_next     = 1'b1;

        // Random part: each pass appends one scenario and ends in a restart.
        while (pending_items.size() < total_items) begin
            bursty   = ($urandom_range(0, 2) != 0);
            scenario = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) drain_next = 1'b1;
            if (scenario < 65) begin
                // Well-formed body: a few chunks, then the zero-size line.
                nchunks = $urandom_range(1, 4);
                repeat (nchunks) begin
                    size = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 16);
                    add_size_line(size);
                    add_data(size);
                    case ($urandom_range(0, 2))
                        0: begin
                            add_item(CMD_PROCESS, CHAR_CR);
                            add_item(CMD_PROCESS, CHAR_LF);
                        end
                        1: add_item(CMD_PROCESS, CHAR_LF);
                        default: begin
                        end
                    endcase
                end
                add_size_line('0);
                add_data($urandom_range(0, 3));
            end else if (scenario < 78) begin
                // Noise, with the odd restart in the middle.
                repeat ($urandom_range(3, 12))
                    add_item(($urandom_range(0, 15) == 0) ? CMD_RESTART : CMD_PROCESS,
                             8'($urandom_range(0, 255)));
            end else if (scenario < 86) begin
                // Size line that starts with neither whitespace nor a digit.
                repeat ($urandom_range(0, 2)) add_item(CMD_PROCESS, rand_space());
                do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) != 5'd0 || is_space(b));
                add_item(CMD_PROCESS, b);
                add_data($urandom_range(1, 4));
            end else if (scenario < 92) begin
                // Size with more digits than the counter holds.
                add_item(CMD_PROCESS, hex_char(4'($urandom_range(1, 15))));
                repeat ($urandom_range(8, 11)) add_item(CMD_PROCESS, hex_char(4'($urandom)));
                add_data($urandom_range(1, 3));
            end else if (scenario < 95) begin
                // Full-width size that fits, cut short by a restart.
                size = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : $urandom | 32'h1000_0000;
                add_size_line(size);
                add_data($urandom_range(1, 10));
            end else begin
                // Ordinary chunk cut off before its data is complete.
                size = $urandom_range(1, 40);
                add_size_line(size);
                add_data($urandom_range(0, size - 1));
            end
            add_item(CMD_RESTART, 8'($urandom_range(0, 255)));
        end
        total_items = pending_items.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_items < total_items) @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
        repeat (END_CYCLES) @(negedge clk);

        $display("Sent %0d body items (%0d restarts, %0d full drains); checked %0d payload bytes,",
                 accepted_items, restart_count, drain_pauses, payload_count);
        $display("%0d body ends and %0d format error results; %0d mismatches.",
                 body_end_count, error_count, fail_count);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
